// ===== sv/pti_pkg.sv =====
// Shared types and constants of the profile table interpolator.
// Request and response words, configuration registers, register map.
// No dependencies.
package pti_pkg;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Q16 constants: one, one half, and the two snap thresholds near a bin
	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [15:0] HALF_Q16 = 16'd32768;
	localparam logic [15:0] NEAR_LO  = 16'd3277;
	localparam logic [15:0] NEAR_HI  = 16'd62260;

	localparam int PADDR_BITS = 4;

	typedef enum logic [1:0] {
		REG_MIN_ENERGY        = 2'd0,
		REG_ENERGY_STEP_RECIP = 2'd1,
		REG_DIST_STEP_RECIP   = 2'd2,
		REG_MAX_DIST          = 2'd3
	} reg_idx_t;

	localparam logic [16:0] RST_ENERGY_STEP_RECIP = 17'd655;
	localparam logic [16:0] RST_DIST_STEP_RECIP   = 17'd6554;
	localparam logic [15:0] RST_MAX_DIST          = 16'd65535;

	typedef struct packed {
		logic [15:0] min_energy;
		logic [16:0] energy_step_recip;
		logic [16:0] dist_step_recip;
		logic [15:0] max_dist;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [1:0]  module_type;
		logic [6:0]  load_energy_bin;
		logic [6:0]  load_dist_bin;
		logic [15:0] load_frac;
		logic [15:0] load_err;
		logic [15:0] query_dist;
		logic [15:0] query_energy;
	} req_t;

	typedef struct packed {
		logic [15:0] profile_frac;
		logic [15:0] profile_err;
		logic        beyond_range;
	} rsp_t;

endpackage

// ===== sv/pti_regs.sv =====
// Configuration register file of the profile table interpolator.
// APB-style write and read access; depends on pti_pkg.
module pti_regs import pti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_energy        <= '0;
			cfg_q.energy_step_recip <= RST_ENERGY_STEP_RECIP;
			cfg_q.dist_step_recip   <= RST_DIST_STEP_RECIP;
			cfg_q.max_dist          <= RST_MAX_DIST;
		end else if (wr) begin
			case (idx)
				REG_MIN_ENERGY:        cfg_q.min_energy        <= pwdata[15:0];
				REG_ENERGY_STEP_RECIP: cfg_q.energy_step_recip <= pwdata[16:0];
				REG_DIST_STEP_RECIP:   cfg_q.dist_step_recip   <= pwdata[16:0];
				REG_MAX_DIST:          cfg_q.max_dist          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_ENERGY:        prdata = {16'd0, cfg_q.min_energy};
			REG_ENERGY_STEP_RECIP: prdata = {15'd0, cfg_q.energy_step_recip};
			REG_DIST_STEP_RECIP:   prdata = {15'd0, cfg_q.dist_step_recip};
			REG_MAX_DIST:          prdata = {16'd0, cfg_q.max_dist};
			default:               prdata = '0;
		endcase
	end

endmodule

// ===== sv/pti_ram.sv =====
// Single-port profile table memory, one access per cycle.
// Registered read data holds while no read is issued; no dependencies.
module pti_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/pti_blend.sv =====
// Linear blend of two table entries in Q16, for fraction and error.
// Registered products, then sum with round half up; depends on pti_pkg.
module pti_blend import pti_pkg::*; #(
	parameter int VALUE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic [2*VALUE_BITS-1:0] lo,
	input  logic [2*VALUE_BITS-1:0] hi,
	input  logic [16:0]             w,
	input  logic                    zero,
	input  logic                    beyond,
	output logic                    res_v,
	output rsp_t                    res
);

	localparam int PW = 17 + VALUE_BITS;
	localparam int SW = (PW + 1 > 32) ? PW + 1 : 32;

	logic [VALUE_BITS-1:0] lo_f, lo_e, hi_f, hi_e;
	logic [16:0]           w_lo;
	logic [PW-1:0]         ph_f_s5, pl_f_s5, ph_e_s5, pl_e_s5;
	logic                  v_s5, zero_s5, beyond_s5;
	logic [SW-1:0]         acc_f, acc_e;

	// a full weight on the upper entry means no lower entry was read
	assign lo_f = w[16] ? '0 : lo[2*VALUE_BITS-1:VALUE_BITS];
	assign lo_e = w[16] ? '0 : lo[VALUE_BITS-1:0];
	assign hi_f = hi[2*VALUE_BITS-1:VALUE_BITS];
	assign hi_e = hi[VALUE_BITS-1:0];
	assign w_lo = ONE_Q16 - w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_f_s5   <= PW'(w) * PW'(hi_f);
			pl_f_s5   <= PW'(w_lo) * PW'(lo_f);
			ph_e_s5   <= PW'(w) * PW'(hi_e);
			pl_e_s5   <= PW'(w_lo) * PW'(lo_e);
			zero_s5   <= zero;
			beyond_s5 <= beyond;
		end
	end

	assign acc_f = SW'(ph_f_s5) + SW'(pl_f_s5) + SW'(HALF_Q16);
	assign acc_e = SW'(ph_e_s5) + SW'(pl_e_s5) + SW'(HALF_Q16);

	assign res_v            = v_s5;
	assign res.profile_frac = zero_s5 ? 16'd0 : acc_f[31:16];
	assign res.profile_err  = zero_s5 ? 16'd0 : acc_e[31:16];
	assign res.beyond_range = beyond_s5;

endmodule

// ===== sv/profile_table_interpolator_unit.sv =====
// Profile table interpolator: top level with pipeline control.
// Uses pti_pkg, pti_regs, pti_ram and pti_blend.
//
// The block keeps a table of (fraction, error) pairs per module type, energy bin and
// distance bin in one single-port memory. A load word (action 0) writes one entry
// and returns nothing; a load with an unknown type or a bin out of range is dropped.
// A query word (action 1) returns one word: zeros with beyond_range set when the
// distance is at or past max_dist, zeros for an unknown module type, else the entry
// at the rounded distance bin, blended linearly in Q16 between two adjacent energy
// bins unless the energy lies within 0.05 of a bin. Energies below min_energy use
// the first bin; energies at or past the last bin use the last bin. The memory
// port sets the pace: a load or a query that needs at most one entry uses the
// port once, an interpolating query reads the lower entry and then the upper one;
// words otherwise follow back to back while the output is not stalled. A result
// passes capture, products, bins, memory read, blend and the output register. An entry
// reads back only after it has been loaded; the table is not cleared at reset.
// Write the configuration registers only while no word is in flight.
module profile_table_interpolator_unit import pti_pkg::*; #(
	parameter int NUM_TYPES   = 4,
	parameter int ENERGY_BINS = 64,
	parameter int DIST_BINS   = 64,
	parameter int VALUE_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int DEPTH = NUM_TYPES * ENERGY_BINS * DIST_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = AW + 1;
	localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int EW    = $clog2(ENERGY_BINS);
	localparam int DW    = (DIST_BINS > 1) ? $clog2(DIST_BINS) : 1;
	localparam int MW    = 2 * VALUE_BITS;

	function automatic logic [AW-1:0] slot(input logic [TW-1:0] t,
	                                       input logic [EW-1:0] e,
	                                       input logic [DW-1:0] d);
		logic [XW-1:0] s;
		s = (XW'(t) * XW'(ENERGY_BINS) + XW'(e)) * XW'(DIST_BINS) + XW'(d);
		return s[AW-1:0];
	endfunction

	cfg_t cfg;

	pti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------- flow control
	// Everything after the issue stage moves in lockstep whenever the output register can
	// take a word; issue also holds through a pair's first read, and the two front stages fill bubbles on their own.
	logic adv, c_last, c_free, s2_free, s1_free;
	logic v_s1, v_s2, v_s3, phase_q;
	logic interp_s3;

	assign adv       = !rsp_valid || !rsp_stall;
	assign c_last    = !interp_s3 || phase_q;
	assign c_free    = !v_s3 || (adv && c_last);
	assign s2_free   = !v_s2 || c_free;
	assign s1_free   = !v_s1 || s2_free;
	assign req_stall = !s1_free;

	// ---------------------------------------------------------------- stage 1: capture
	req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			req_s1 <= req;
		end
	end

	// ---------------------------------------------------------------- stage 2: products
	// distance bin rounds half up; energy product splits into bin and Q16 residue
	logic [33:0]           dprod;
	logic [15:0]           ediff;
	logic [32:0]           eprod;
	logic                  act_s2, type_ok_s2, beyond_s2, low_s2, ld_ok_s2;
	logic [1:0]            type_s2;
	logic [17:0]           db_s2;
	logic [16:0]           eb_s2;
	logic [15:0]           r_s2;
	logic [6:0]            le_s2, ld_s2;
	logic [MW-1:0]         wd_s2;

	assign dprod = 34'(34'(req_s1.query_dist) * 34'(cfg.dist_step_recip)) + 34'(HALF_Q16);
	assign ediff = req_s1.query_energy - cfg.min_energy;
	assign eprod = 33'(ediff) * 33'(cfg.energy_step_recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			act_s2     <= req_s1.action;
			type_s2    <= req_s1.module_type;
			type_ok_s2 <= 5'(req_s1.module_type) < 5'(NUM_TYPES);
			beyond_s2  <= req_s1.query_dist >= cfg.max_dist;
			low_s2     <= req_s1.query_energy < cfg.min_energy;
			ld_ok_s2   <= (8'(req_s1.load_energy_bin) < 8'(ENERGY_BINS)) &&
			              (8'(req_s1.load_dist_bin) < 8'(DIST_BINS));
			db_s2      <= dprod[33:16];
			eb_s2      <= eprod[32:16];
			r_s2       <= eprod[15:0];
			le_s2      <= req_s1.load_energy_bin;
			ld_s2      <= req_s1.load_dist_bin;
			wd_s2      <= {VALUE_BITS'(req_s1.load_frac), VALUE_BITS'(req_s1.load_err)};
		end
	end

	// ---------------------------------------------------------------- stage 3: bins
	logic [DW-1:0] d_sel;
	logic [EW-1:0] e_sel;
	logic          e_top, interp_c, is_query;
	logic [TW-1:0] t_sel;

	assign is_query = (act_s2 == ACT_QUERY);
	assign t_sel    = TW'(type_s2);
	assign d_sel    = (db_s2 >= 18'(DIST_BINS)) ? DW'(DIST_BINS - 1) : DW'(db_s2);
	assign e_top    = (18'(eb_s2) + 18'd1) >= 18'(ENERGY_BINS);

	always_comb begin
		interp_c = 1'b0;
		if (low_s2) begin
			e_sel = '0;
		end else if (e_top) begin
			e_sel = EW'(ENERGY_BINS - 1);
		end else if (r_s2 < NEAR_LO) begin
			e_sel = EW'(eb_s2);
		end else if (r_s2 >= NEAR_HI) begin
			e_sel = EW'(eb_s2) + EW'(1);
		end else begin
			e_sel    = EW'(eb_s2);
			interp_c = 1'b1;
		end
	end

	logic          load_s3, query_s3, rd_s3, beyond_s3;
	logic [AW-1:0] a0_s3, a1_s3;
	logic [16:0]   w_s3;
	logic [MW-1:0] wd_s3;
	logic          rd_c;

	assign rd_c = is_query && type_ok_s2 && !beyond_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (c_free) begin
				v_s3 <= v_s2;
			end
			// second half of an interpolating query follows the first
			if (adv && v_s3) begin
				phase_q <= interp_s3 && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c_free) begin
			load_s3   <= !is_query && type_ok_s2 && ld_ok_s2;
			query_s3  <= is_query;
			rd_s3     <= rd_c;
			beyond_s3 <= beyond_s2;
			interp_s3 <= rd_c && interp_c;
			w_s3      <= (rd_c && interp_c) ? {1'b0, r_s2} : ONE_Q16;
			wd_s3     <= wd_s2;
			if (is_query) begin
				a0_s3 <= slot(t_sel, e_sel, d_sel);
			end else begin
				a0_s3 <= slot(t_sel, EW'(le_s2), DW'(ld_s2));
			end
			a1_s3 <= slot(t_sel, e_sel + EW'(1), d_sel);
		end
	end

	// ---------------------------------------------------------------- memory port
	// Accesses issue in word order through the one port, so a query always sees
	// every earlier load.
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [MW-1:0] mem_q;

	assign mem_we   = adv && v_s3 && load_s3;
	assign mem_re   = adv && v_s3 && rd_s3;
	assign mem_addr = (interp_s3 && phase_q) ? a1_s3 : a0_s3;

	pti_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.WIDTH (MW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (wd_s3),
		.rdata (mem_q)
	);

	// ---------------------------------------------------------------- read return
	// tag tells what the read data register holds: the lower entry of a pair, or
	// the entry that completes a query
	logic          tag_v_q, tag_first_q, tag_zero_q, tag_beyond_q;
	logic [16:0]   tag_w_q;
	logic [MW-1:0] lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_v_q     <= 1'b0;
			tag_first_q <= 1'b0;
		end else if (adv) begin
			tag_v_q     <= v_s3 && query_s3 && c_last;
			tag_first_q <= v_s3 && interp_s3 && !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_w_q      <= w_s3;
			tag_zero_q   <= !rd_s3;
			tag_beyond_q <= beyond_s3;
			// hold the lower entry while the upper one is read
			if (tag_first_q) begin
				lo_q <= mem_q;
			end
		end
	end

	// ---------------------------------------------------------------- blend and output
	logic blend_v;
	rsp_t blend_res;

	pti_blend #(
		.VALUE_BITS (VALUE_BITS)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (tag_v_q),
		.lo     (lo_q),
		.hi     (mem_q),
		.w      (tag_w_q),
		.zero   (tag_zero_q),
		.beyond (tag_beyond_q),
		.res_v  (blend_v),
		.res    (blend_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= blend_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= blend_res;
		end
	end

endmodule
